FILE: hdl/pump_dry_run_controller_core_defines.svh
// Assertion helpers for the asserting core module.
`ifndef PUMP_DRY_RUN_CONTROLLER_CORE_DEFINES_SVH
`define PUMP_DRY_RUN_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, muted while reset is low.
`define PDRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is low.
`define PDRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pdrc_pkg.sv
package pdrc_pkg;

    localparam int DEF_PULSE_BITS = 8;
    localparam int DEF_COUNT_BITS = 16;

    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_LOCK_TICKS    = 2'd0;
    localparam logic [1:0] REG_PRIMING_TICKS = 2'd1;
    localparam logic [1:0] REG_MANUAL_MODE   = 2'd2;

    // operation codes
    localparam logic [2:0] OP_FLOW_SAMPLE = 3'd0;
    localparam logic [2:0] OP_TICK        = 3'd1;
    localparam logic [2:0] OP_BLINK       = 3'd2;
    localparam logic [2:0] OP_CLR_TRIP    = 3'd3;
    localparam logic [2:0] OP_CLR_TOTALS  = 3'd4;

    // machine states
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_CHECK  = 2'd1;
    localparam logic [1:0] MODE_LOCKED = 2'd2;

    localparam logic [1:0] LEVEL_EMPTY = 2'd0;
    localparam logic [1:0] LEVEL_FULL  = 2'd2;

    // flow in Q10 L/min: 1239 * pulses + 63, saturating
    localparam logic [18:0] FLOW_SLOPE  = 19'd1239;
    localparam logic [18:0] FLOW_OFFSET = 19'd63;
    localparam logic [18:0] FLOW_START  = FLOW_SLOPE + FLOW_OFFSET;
    localparam logic [18:0] FLOW_MAX    = 19'h7FFFF;
    localparam logic [18:0] LOW_FLOW    = 19'd5120;
    localparam logic [20:0] LITRE_SUM   = 21'd613174;
    localparam int          LITRES_PER_M3 = 1000;
    localparam int          LOCK_DIV      = 10;

    localparam logic [14:0] RST_LOCK_TICKS    = 15'd600;
    localparam logic [14:0] RST_PRIMING_TICKS = 15'd300;

    typedef struct packed {
        logic        pump_on;
        logic        led_on;
        logic [1:0]  machine_state;
        logic [18:0] flow_rate;
        logic [9:0]  litres;
        logic [15:0] cubic_metres;
        logic [15:0] trip_litres;
        logic [11:0] locked_seconds;
        logic [1:0]  cistern_level;
    } t_status;

endpackage

FILE: hdl/pdrc_in_if.sv
interface pdrc_in_if import pdrc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic       flow_pin;
    logic       level_low_sensor;
    logic       level_high_sensor;
    logic       button;

    modport source (output valid, operation, flow_pin, level_low_sensor,
                    level_high_sensor, button, input ready);
    modport sink   (input valid, operation, flow_pin, level_low_sensor,
                    level_high_sensor, button, output ready);
endinterface

FILE: hdl/pdrc_out_if.sv
interface pdrc_out_if import pdrc_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        pump_on;
    logic        led_on;
    logic [1:0]  machine_state;
    logic [18:0] flow_rate;
    logic [9:0]  litres;
    logic [15:0] cubic_metres;
    logic [15:0] trip_litres;
    logic [11:0] locked_seconds;
    logic [1:0]  cistern_level;

    modport source (output valid, pump_on, led_on, machine_state, flow_rate, litres,
                    cubic_metres, trip_litres, locked_seconds, cistern_level,
                    input ready);
    modport sink   (input valid, pump_on, led_on, machine_state, flow_rate, litres,
                    cubic_metres, trip_litres, locked_seconds, cistern_level,
                    output ready);
endinterface

FILE: hdl/pump_dry_run_controller_core.sv
// Pump controller with dry-run lockout.
// Input channel i_in carries one event beat: flow pin sample, 100 ms control
// tick, lamp blink tick, clear trip count or clear totals, together with the
// float switches and the start button. Every accepted beat yields exactly one
// status beat on o_out: pump drive, lamp, machine state, flow rate (Q10 L/min),
// litres, cubic metres, trip litres, locked seconds and cistern level.
// The status of a beat is registered: valid the cycle after accept if the
// output is free. One beat per cycle while i_in.ready is high; all state updates in the accept cycle.
// Flow rate is kept as a running sum (1239 per pulse), and locked seconds as
// a quotient/remainder pair, so no multiplier or divider is in the path.
// An output register plus a one-beat skid register part the channels: a new
// beat is taken while a status waits, and i_in.ready drops whenever the skid
// is full.
// The APB port holds lock_ticks (0x0), priming_ticks (0x4) and manual_mode
// (0x8); writing manual_mode also stops the pump and idles the machine.
// Reset (synchronous, active low) clears all counters, idles the machine and
// loads the register defaults: lock 600, priming 300, manual off. i_in.ready
// stays low while reset is held.
`include "pump_dry_run_controller_core_defines.svh"

module pump_dry_run_controller_core import pdrc_pkg::*; #(
    parameter int PULSE_BITS = DEF_PULSE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pdrc_in_if.sink              i_in,
    pdrc_out_if.source           o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    // configuration
    logic [14:0] r_lock_ticks, n_lock_ticks;
    logic [14:0] r_prime_ticks, n_prime_ticks;
    logic        r_manual, n_manual;

    // controller state
    logic                  r_last_pin, n_last_pin;
    logic [PULSE_BITS-1:0] r_pulse, n_pulse;
    logic [18:0]           r_pend, n_pend;     // flow the current pulse count gives
    logic [18:0]           r_flow, n_flow;
    logic [19:0]           r_acc, n_acc;
    logic [9:0]            r_litre, n_litre;
    logic [COUNT_BITS-1:0] r_cubic, n_cubic;
    logic [COUNT_BITS-1:0] r_trip, n_trip;
    logic [1:0]            r_mode, n_mode;
    logic [15:0]           r_prime, n_prime;
    logic [15:0]           r_lock, n_lock;
    logic [12:0]           r_lock_sec, n_lock_sec; // lock_counter / 10
    logic [3:0]            r_lock_rem, n_lock_rem; // lock_counter % 10
    logic                  r_drive, n_drive;
    logic                  r_lamp, n_lamp;

    // output and skid stages
    logic    r_out_vld, r_skid_vld;
    t_status r_out, r_skid;
    t_status status;

    logic        accept;
    logic        out_free;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [1:0]  level;
    logic [19:0] pend_sum;
    logic [20:0] acc_sum;
    logic [15:0] prime_inc;
    logic [15:0] lock_inc;
    logic        low_flow;
    logic        run;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[3:2];
    assign cfg_we   = psel && penable && pwrite;

    assign i_in.ready = i_rst_n && !r_skid_vld;
    assign accept     = i_in.valid && i_rst_n && !r_skid_vld;
    assign out_free   = !r_out_vld || o_out.ready;

    assign level = {1'b0, i_in.level_low_sensor} + {1'b0, i_in.level_high_sensor};

    always_comb begin
        unique case (cfg_idx)
            REG_LOCK_TICKS:    prdata = {17'd0, r_lock_ticks};
            REG_PRIMING_TICKS: prdata = {17'd0, r_prime_ticks};
            REG_MANUAL_MODE:   prdata = {31'd0, r_manual};
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        n_lock_ticks  = r_lock_ticks;
        n_prime_ticks = r_prime_ticks;
        n_manual      = r_manual;
        n_last_pin    = r_last_pin;
        n_pulse       = r_pulse;
        n_pend        = r_pend;
        n_flow        = r_flow;
        n_acc         = r_acc;
        n_litre       = r_litre;
        n_cubic       = r_cubic;
        n_trip        = r_trip;
        n_mode        = r_mode;
        n_prime       = r_prime;
        n_lock        = r_lock;
        n_lock_sec    = r_lock_sec;
        n_lock_rem    = r_lock_rem;
        n_drive       = r_drive;
        n_lamp        = r_lamp;

        pend_sum  = {1'b0, r_pend} + {1'b0, FLOW_SLOPE};
        acc_sum   = {1'b0, r_acc} + {2'b0, r_pend};
        prime_inc = r_prime + 16'd1;
        lock_inc  = r_lock + 16'd1;
        low_flow  = r_pend < LOW_FLOW;
        run       = 1'b0;

        if (accept) begin
            unique case (i_in.operation)
                OP_FLOW_SAMPLE: begin
                    // count rising edges, saturate the count
                    if (i_in.flow_pin != r_last_pin) begin
                        if (i_in.flow_pin && !(&r_pulse)) begin
                            n_pulse = r_pulse + PULSE_BITS'(1);
                            if (r_pulse == '0) begin
                                n_pend = FLOW_START;
                            end else if (pend_sum > {1'b0, FLOW_MAX}) begin
                                n_pend = FLOW_MAX;
                            end else begin
                                n_pend = pend_sum[18:0];
                            end
                        end
                        n_last_pin = i_in.flow_pin;
                    end
                end
                OP_TICK: begin
                    n_flow  = r_pend;
                    n_pulse = '0;
                    n_pend  = '0;

                    // integrate volume, drop the excess at each litre
                    if (acc_sum >= LITRE_SUM) begin
                        n_acc  = '0;
                        n_trip = r_trip + COUNT_BITS'(1);
                        if (r_litre == 10'(LITRES_PER_M3 - 1)) begin
                            n_litre = '0;
                            n_cubic = r_cubic + COUNT_BITS'(1);
                        end else begin
                            n_litre = r_litre + 10'd1;
                        end
                    end else begin
                        n_acc = acc_sum[19:0];
                    end

                    unique case (r_mode)
                        MODE_IDLE: begin
                            if (r_drive && low_flow) begin
                                n_prime = '0;
                                n_mode  = MODE_CHECK;
                            end
                        end
                        MODE_CHECK: begin
                            n_prime = prime_inc;
                            if (prime_inc > {1'b0, r_prime_ticks}) begin
                                n_lock     = '0;
                                n_lock_sec = '0;
                                n_lock_rem = '0;
                                n_mode     = MODE_LOCKED;
                                n_drive    = 1'b0;
                                n_lamp     = 1'b0;
                            end else if (!low_flow) begin
                                n_mode = MODE_IDLE;
                            end
                        end
                        default: begin
                            n_lock = lock_inc;
                            if (r_lock == 16'hFFFF) begin
                                n_lock_sec = '0;
                                n_lock_rem = '0;
                            end else if (r_lock_rem == 4'(LOCK_DIV - 1)) begin
                                n_lock_sec = r_lock_sec + 13'd1;
                                n_lock_rem = '0;
                            end else begin
                                n_lock_rem = r_lock_rem + 4'd1;
                            end
                            if (lock_inc > {1'b0, r_lock_ticks}) begin
                                n_mode = MODE_IDLE;
                            end
                        end
                    endcase

                    // a full cistern releases the lock; drive holds this tick
                    if (n_mode == MODE_LOCKED && level == LEVEL_FULL) begin
                        n_mode = MODE_IDLE;
                        n_lamp = 1'b0;
                    end else begin
                        if (r_manual) begin
                            run = n_drive || i_in.button;
                        end else begin
                            run = (n_drive || level == LEVEL_EMPTY || i_in.button)
                                  && level != LEVEL_FULL;
                        end
                        if (n_mode == MODE_LOCKED) begin
                            run = 1'b0;
                        end
                        n_drive = run;
                        if (n_mode != MODE_LOCKED) begin
                            n_lamp = run;
                        end
                    end
                end
                OP_BLINK: begin
                    if (r_mode == MODE_LOCKED) begin
                        n_lamp = !r_lamp;
                    end
                end
                OP_CLR_TRIP: begin
                    n_trip = '0;
                end
                OP_CLR_TOTALS: begin
                    n_trip  = '0;
                    n_litre = '0;
                    n_cubic = '0;
                    n_flow  = '0;
                    n_pulse = '0;
                    n_pend  = '0;
                end
                default: begin
                end
            endcase
        end

        // the user must write only while the block is idle; the block itself does not enforce it
        if (cfg_we) begin
            unique case (cfg_idx)
                REG_LOCK_TICKS:    n_lock_ticks  = pwdata[14:0];
                REG_PRIMING_TICKS: n_prime_ticks = pwdata[14:0];
                REG_MANUAL_MODE: begin
                    n_manual = pwdata[0];
                    n_drive  = 1'b0;
                    n_mode   = MODE_IDLE;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        status.pump_on        = n_drive;
        status.led_on         = n_lamp;
        status.machine_state  = n_mode;
        status.flow_rate      = n_flow;
        status.litres         = n_litre;
        status.cubic_metres   = n_cubic[15:0];
        status.trip_litres    = n_trip[15:0];
        status.locked_seconds = n_lock_sec[11:0];
        status.cistern_level  = level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_ticks  <= RST_LOCK_TICKS;
            r_prime_ticks <= RST_PRIMING_TICKS;
            r_manual      <= 1'b0;
            r_last_pin    <= 1'b0;
            r_pulse       <= '0;
            r_pend        <= '0;
            r_flow        <= '0;
            r_acc         <= '0;
            r_litre       <= '0;
            r_cubic       <= '0;
            r_trip        <= '0;
            r_mode        <= MODE_IDLE;
            r_prime       <= '0;
            r_lock        <= '0;
            r_lock_sec    <= '0;
            r_lock_rem    <= '0;
            r_drive       <= 1'b0;
            r_lamp        <= 1'b0;
        end else begin
            r_lock_ticks  <= n_lock_ticks;
            r_prime_ticks <= n_prime_ticks;
            r_manual      <= n_manual;
            r_last_pin    <= n_last_pin;
            r_pulse       <= n_pulse;
            r_pend        <= n_pend;
            r_flow        <= n_flow;
            r_acc         <= n_acc;
            r_litre       <= n_litre;
            r_cubic       <= n_cubic;
            r_trip        <= n_trip;
            r_mode        <= n_mode;
            r_prime       <= n_prime;
            r_lock        <= n_lock;
            r_lock_sec    <= n_lock_sec;
            r_lock_rem    <= n_lock_rem;
            r_drive       <= n_drive;
            r_lamp        <= n_lamp;
        end
    end

    // output register with one skid beat behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld  <= r_skid_vld || accept;
            r_skid_vld <= 1'b0;
        end else if (accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_vld ? r_skid : status;
        end else if (accept) begin
            r_skid <= status;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.pump_on        = r_out.pump_on;
    assign o_out.led_on         = r_out.led_on;
    assign o_out.machine_state  = r_out.machine_state;
    assign o_out.flow_rate      = r_out.flow_rate;
    assign o_out.litres         = r_out.litres;
    assign o_out.cubic_metres   = r_out.cubic_metres;
    assign o_out.trip_litres    = r_out.trip_litres;
    assign o_out.locked_seconds = r_out.locked_seconds;
    assign o_out.cistern_level  = r_out.cistern_level;

    // skid holds a beat only behind a pending output beat
    `PDRC_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid beat without output beat")
    // a beat taken while the receiver stalls lands in the skid
    `PDRC_ASSERT_NEXT(a_stall_to_skid, i_clk, i_rst_n, accept && r_out_vld && !o_out.ready, r_skid_vld, "stalled beat lost")
    // the pump never runs while locked
    `PDRC_ASSERT_NOW(a_locked_pump_off, i_clk, i_rst_n, r_mode == MODE_LOCKED, !r_drive, "pump driven while locked")
    // lock seconds remainder stays a decimal digit
    `PDRC_ASSERT_NOW(a_lock_rem_digit, i_clk, i_rst_n, 1'b1, r_lock_rem < 4'(LOCK_DIV), "lock remainder out of range")
    // litres wrap into cubic metres
    `PDRC_ASSERT_NOW(a_litre_range, i_clk, i_rst_n, 1'b1, r_litre < 10'(LITRES_PER_M3), "litre count out of range")

endmodule
